/* src/bole_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bole_pkg;

  // Default capacity of the list.
  localparam int DEPTH_DEF = 16;

  // Fixed field widths.
  localparam int FUNC_W   = 3;
  localparam int INDEX_W  = 4;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Operation codes.
  localparam logic [FUNC_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [FUNC_W-1:0] OP_POP    = 3'd1;
  localparam logic [FUNC_W-1:0] OP_INSERT = 3'd2;
  localparam logic [FUNC_W-1:0] OP_ERASE  = 3'd3;
  localparam logic [FUNC_W-1:0] OP_GET    = 3'd4;
  localparam logic [FUNC_W-1:0] OP_SET    = 3'd5;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic ins;  // open a gap at pos and write the request word there
    logic era;  // close the gap at pos by pulling from the right
    logic wr;   // overwrite the cell at pos
    logic rd;   // a successful read is in progress
  } cmd_t;

endpackage

`default_nettype wire

/* src/bounded_ordered_list_engine.sv */
`timescale 1ns / 1ps
`default_nettype none

// Bounded ordered list engine. The block keeps an ordered list of up to DEPTH
// signed 32-bit words in a row of cells, one word per cell, plus an entry
// count. Each request names an operation in tuser: push, pop, insert, erase,
// get or set. Insert and erase move every later word by one place in the
// same clock, because each cell loads from its left or right neighbor at
// once. A request that cannot be carried out (bad index, full or empty) gets
// an error status and leaves the list untouched; unused operation codes do
// nothing and report success. Every request yields exactly one response that
// carries the word read by a successful get (zero otherwise), the status and
// the entry count after the request, masked to five bits. A request is decoded
// against the count register and applied to all cells at the same edge as
// its response lands in an output register, so a new request is taken every
// cycle while the response side keeps up. Only the first sixteen positions
// can be named by index; the rest are reached by push, pop and the shifts.
module bounded_ordered_list_engine #(
  parameter int DEPTH = bole_pkg::DEPTH_DEF
) (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  // Request channel.
  input  wire  logic        s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire  logic [39:0] s_axis_tdata_i,   // [3:0] index, [35:4] value, rest zero
  input  wire  logic [2:0]  s_axis_tuser_i,   // [2:0] func
  // Response channel.
  output logic              m_axis_tvalid_o,
  input  wire  logic        m_axis_tready_i,
  output logic [39:0]       m_axis_tdata_o,   // [31:0] read_value, [36:32] count, rest zero
  output logic [1:0]        m_axis_tuser_o    // [1:0] status
);
  import bole_pkg::*;

  localparam int CntW  = $clog2(DEPTH + 1);
  // Number of cells reachable through the index field.
  localparam int NumRd = (DEPTH < (1 << INDEX_W)) ? DEPTH : (1 << INDEX_W);

  logic                 req;
  logic [INDEX_W-1:0]   index;
  logic [WORD_W-1:0]    value;
  cmd_t                 cmd;
  logic [CntW-1:0]      pos;
  logic [STATUS_W-1:0]  status;
  logic [CntW-1:0]      count;
  logic [WORD_W-1:0]    cell_data [DEPTH];
  logic [WORD_W-1:0]    rd_word;

  logic                 out_valid_q;
  logic [WORD_W-1:0]    rd_q;
  logic [STATUS_W-1:0]  status_q;
  logic [COUNT_W-1:0]   count_q;
  logic [COUNT_W-1:0]   count_out;

  assign index = s_axis_tdata_i[INDEX_W-1:0];
  assign value = s_axis_tdata_i[INDEX_W +: WORD_W];

  // The output register frees up whenever the response is taken.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign req             = s_axis_tvalid_i && s_axis_tready_o;

  bole_ctrl #(
    .DEPTH (DEPTH),
    .CNT_W (CntW)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .func_i   (s_axis_tuser_i),
    .index_i  (index),
    .cmd_o    (cmd),
    .pos_o    (pos),
    .status_o (status),
    .count_o  (count)
  );

  // The row of cells. The end cells feed back their own word where there is
  // no neighbor; that word is never used because those moves fall outside
  // the occupied part of the list.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] left;
    logic [WORD_W-1:0] right;

    if (i == 0) begin : g_first
      assign left = cell_data[i];
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end

    bole_cell #(
      .CNT_W (CntW),
      .POS   (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .pos_i   (pos),
      .value_i (value),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i])
    );
  end

  // Read select over the cells that an index can name.
  always_comb begin
    rd_word = '0;
    for (int k = 0; k < NumRd; k++) begin
      if (cmd.rd && (index == INDEX_W'(k))) begin
        rd_word = cell_data[k];
      end
    end
  end

  assign count_out = COUNT_W'(count);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req) begin
      rd_q     <= rd_word;
      status_q <= status;
      count_q  <= count_out;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, count_q, rd_q};
  assign m_axis_tuser_o  = status_q;

endmodule

`default_nettype wire

/* src/bole_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module bole_cell #(
  parameter int CNT_W = 5,
  parameter int POS   = 0
) (
  input  wire  logic                      clk_i,
  input  wire  bole_pkg::cmd_t            cmd_i,
  input  wire  logic [CNT_W-1:0]          pos_i,
  input  wire  logic [bole_pkg::WORD_W-1:0] value_i,
  input  wire  logic [bole_pkg::WORD_W-1:0] left_i,
  input  wire  logic [bole_pkg::WORD_W-1:0] right_i,
  output logic [bole_pkg::WORD_W-1:0]       data_o
);
  import bole_pkg::*;

  localparam logic [CNT_W-1:0] MyPos = CNT_W'(POS);

  logic [WORD_W-1:0] data_q;
  logic [WORD_W-1:0] data_d;

  // Each cell only looks at its own position against the broadcast one.
  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (MyPos == pos_i) begin
        data_d = value_i;
      end else if (MyPos > pos_i) begin
        data_d = left_i;
      end
    end else if (cmd_i.era) begin
      if (MyPos >= pos_i) begin
        data_d = right_i;
      end
    end else if (cmd_i.wr) begin
      if (MyPos == pos_i) begin
        data_d = value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

/* src/bole_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module bole_ctrl #(
  parameter int DEPTH = bole_pkg::DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire  logic                          clk_i,
  input  wire  logic                          rst_ni,
  input  wire  logic                          req_i,
  input  wire  logic [bole_pkg::FUNC_W-1:0]   func_i,
  input  wire  logic [bole_pkg::INDEX_W-1:0]  index_i,
  output bole_pkg::cmd_t                      cmd_o,
  output logic [CNT_W-1:0]                    pos_o,
  output logic [bole_pkg::STATUS_W-1:0]       status_o,
  output logic [CNT_W-1:0]                    count_o
);
  import bole_pkg::*;

  // Common width for comparing the index with the entry count.
  localparam int CmpW = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam logic [CNT_W-1:0] Full = CNT_W'(DEPTH);

  logic [CNT_W-1:0] used_q;
  logic [CNT_W-1:0] used_d;
  logic [CmpW-1:0]  idx_e;
  logic [CmpW-1:0]  used_e;
  logic             full;
  logic             empty;
  logic [CNT_W-1:0] idx_pos;
  cmd_t             cmd;

  assign idx_e   = CmpW'(index_i);
  assign used_e  = CmpW'(used_q);
  assign full    = (used_q == Full);
  assign empty   = (used_q == '0);
  // Whenever the index is accepted it is at most used, so it fits here.
  assign idx_pos = CNT_W'(idx_e);

  always_comb begin
    cmd      = '0;
    pos_o    = idx_pos;
    status_o = ST_OK;
    used_d   = used_q;
    case (func_i)
      OP_PUSH: begin
        if (full) begin
          status_o = ST_FULL;
        end else begin
          cmd.wr = 1'b1;
          pos_o  = used_q;
          used_d = used_q + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (empty) begin
          status_o = ST_EMPTY;
        end else begin
          used_d = used_q - CNT_W'(1);
        end
      end
      OP_INSERT: begin
        if (full) begin
          status_o = ST_FULL;
        end else if (idx_e > used_e) begin
          status_o = ST_RANGE;
        end else begin
          cmd.ins = 1'b1;
          used_d  = used_q + CNT_W'(1);
        end
      end
      OP_ERASE: begin
        if (idx_e >= used_e) begin
          status_o = ST_RANGE;
        end else begin
          cmd.era = 1'b1;
          used_d  = used_q - CNT_W'(1);
        end
      end
      OP_GET: begin
        if (idx_e >= used_e) begin
          status_o = ST_RANGE;
        end else begin
          cmd.rd = 1'b1;
        end
      end
      OP_SET: begin
        if (idx_e >= used_e) begin
          status_o = ST_RANGE;
        end else begin
          cmd.wr = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Cells only move when a request is actually taken.
  assign cmd_o   = req_i ? cmd : '0;
  assign count_o = used_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (req_i) begin
      used_q <= used_d;
    end
  end

endmodule

`default_nettype wire
